FILE: sv/fpst_pkg.sv
package fpst_pkg;

  localparam int SIZE   = 1024;
  localparam int IDX_W  = $clog2(SIZE);
  localparam int POS_W  = 11;
  localparam int DATA_W = 64;
  localparam int REQ_W  = 2;

  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture a new update or query
    logic step;       // read the next tree entry and advance the index
    logic clr_start;  // restart the clearing sweep
    logic clr_step;   // zero one entry of the sweep
    logic out_load;   // move the finished sum into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;  // no more entries to visit
    logic pend;       // read data of the previous step still to be used
    logic clr_last;   // sweep is at the last entry
    logic out_busy;   // output register holds an untaken item
  } sts_t;

endpackage

FILE: sv/fpst_datapath.sv
module fpst_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [fpst_pkg::REQ_W-1:0]      in_req_type,
  input  logic [fpst_pkg::POS_W-1:0]      in_position,
  input  logic signed [fpst_pkg::DATA_W-1:0] in_delta,
  input  fpst_pkg::cmd_t                  cmd,
  output fpst_pkg::sts_t                  sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic signed [fpst_pkg::DATA_W-1:0] out_prefix_sum
);

  logic [fpst_pkg::DATA_W-1:0] mem [fpst_pkg::SIZE];

  logic                         is_query_r;
  logic [fpst_pkg::POS_W-1:0]   idx_r;
  logic [fpst_pkg::DATA_W-1:0]  delta_r;
  logic [fpst_pkg::DATA_W-1:0]  acc_r;
  logic [fpst_pkg::DATA_W-1:0]  rd_data_r;
  logic [fpst_pkg::IDX_W-1:0]   wb_addr_r;
  logic [fpst_pkg::IDX_W-1:0]   clr_cnt_r;
  logic                         pend_r;
  logic                         out_valid_r;
  logic [fpst_pkg::DATA_W-1:0]  out_sum_r;

  logic [fpst_pkg::POS_W-1:0]   idx_dec;
  logic [fpst_pkg::POS_W-1:0]   idx_next;
  logic [fpst_pkg::POS_W-1:0]   pos_sat;
  logic [fpst_pkg::IDX_W-1:0]   rd_addr;

  assign idx_dec  = idx_r - fpst_pkg::POS_W'(1);
  // query clears the lowest set bit, update sets the lowest clear bit
  assign idx_next = is_query_r ? (idx_r & idx_dec) : (idx_r | (idx_r + fpst_pkg::POS_W'(1)));
  assign rd_addr  = is_query_r ? idx_dec[fpst_pkg::IDX_W-1:0] : idx_r[fpst_pkg::IDX_W-1:0];
  assign pos_sat  = (in_position > fpst_pkg::POS_W'(fpst_pkg::SIZE)) ?
                    fpst_pkg::POS_W'(fpst_pkg::SIZE) : in_position;

  always_comb begin
    sts.walk_done = is_query_r ? (idx_r == '0) : (idx_r >= fpst_pkg::POS_W'(fpst_pkg::SIZE));
    sts.pend      = pend_r;
    sts.clr_last  = (clr_cnt_r == fpst_pkg::IDX_W'(fpst_pkg::SIZE - 1));
    sts.out_busy  = out_valid_r;
  end

  // tree storage: one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= '0;
    end else if (pend_r && !is_query_r) begin
      mem[wb_addr_r] <= rd_data_r + delta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_query_r <= (in_req_type == fpst_pkg::REQ_QUERY);
      idx_r      <= (in_req_type == fpst_pkg::REQ_QUERY) ? pos_sat : in_position;
      delta_r    <= in_delta;
      acc_r      <= '0;
    end else begin
      if (cmd.step) begin
        idx_r     <= idx_next;
        wb_addr_r <= rd_addr;
      end
      if (pend_r && is_query_r) begin
        acc_r <= acc_r + rd_data_r;
      end
    end
    if (cmd.out_load) begin
      out_sum_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      pend_r <= cmd.step;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + fpst_pkg::IDX_W'(1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prefix_sum = out_sum_r;

endmodule

FILE: sv/fpst_ctrl.sv
module fpst_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [fpst_pkg::REQ_W-1:0] in_req_type,
  output logic                       in_ready,
  input  logic                       out_ready,
  input  fpst_pkg::sts_t             sts,
  output fpst_pkg::cmd_t             cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   is_query_r;
  logic   is_query_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    is_query_nxt  = is_query_r;
    cmd           = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            fpst_pkg::REQ_UPDATE,
            fpst_pkg::REQ_QUERY: begin
              cmd.load     = 1'b1;
              is_query_nxt = (in_req_type == fpst_pkg::REQ_QUERY);
              state_nxt    = ST_WALK;
            end
            fpst_pkg::REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd.step = !sts.walk_done;
        if (sts.walk_done && !sts.pend) begin
          state_nxt = is_query_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      is_query_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      is_query_r <= is_query_nxt;
    end
  end

  a_no_step_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.clr_step))
    else $error("walk step during clearing sweep");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!sts.out_busy || out_ready))
    else $error("untaken result overwritten");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken before clearing sweep");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pend |-> (state_r == ST_WALK))
    else $error("read data pending outside walk");

endmodule

FILE: sv/fenwick_prefix_sum_tree.sv
// binary indexed tree over 1024 signed 64-bit counters
// input channel (in_valid/in_ready): in_req_type 0 adds in_delta at in_position,
//   1 asks for the sum of elements [0, in_position), 2 zeroes the whole tree,
//   3 is taken and ignored; an update at a position of 1024 or more changes nothing
// result channel (out_valid/out_ready): one item per query, carrying out_prefix_sum,
//   wrapping modulo 2^64
// one item at a time: the walk visits one tree entry per cycle through a single
//   read port and a single write port, with the write-back of one entry
//   overlapping the read of the next
// update: k entries visited from accept to next accept, k from 1 to 11;
//   none when the position is 1024 or more
// query: k entries visited before the result register is loaded, k at most 10,
//   none for an empty prefix; the next accept follows the load
// clear: one entry zeroed per cycle by the sweep
// after reset the same sweep runs and in_ready stays low meanwhile
// the result sits in an output register; while it is untaken the block still
//   accepts updates and clears, and a further query waits only for that
//   register to be free before finishing
module fenwick_prefix_sum_tree (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fpst_pkg::REQ_W-1:0]         in_req_type,
  input  logic [fpst_pkg::POS_W-1:0]         in_position,
  input  logic signed [fpst_pkg::DATA_W-1:0] in_delta,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fpst_pkg::DATA_W-1:0] out_prefix_sum
);

  // command and status between sequencer and datapath
  fpst_pkg::cmd_t cmd;
  fpst_pkg::sts_t sts;

  // sequencer: clearing sweep, walk control and result hand-off
  fpst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath: tree memory, index walk, accumulator and output register
  fpst_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_delta       (in_delta),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_prefix_sum (out_prefix_sum)
  );

endmodule

FILE: test/fpst_sum_checker.sv
`timescale 1ns / 1ps
module fpst_sum_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [fpst_pkg::REQ_W-1:0]         in_req_type,
  input  logic [fpst_pkg::POS_W-1:0]         in_position,
  input  logic signed [fpst_pkg::DATA_W-1:0] in_delta,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [fpst_pkg::DATA_W-1:0] out_prefix_sum,
  output int                                 err_count,
  output int                                 sums_owed
);

  // shadow copy of the tree entries
  logic [fpst_pkg::DATA_W-1:0]        node_sum [fpst_pkg::SIZE];
  logic signed [fpst_pkg::DATA_W-1:0] owed_sums [$];
  int                                 errs;

  // upward walk: set the lowest clear bit
  function automatic void add_at(int unsigned idx, logic [fpst_pkg::DATA_W-1:0] amount);
    while (idx < fpst_pkg::SIZE) begin
      node_sum[idx] += amount;
      idx |= idx + 1;
    end
  endfunction

  // downward walk: clear the lowest set bit
  function automatic logic [fpst_pkg::DATA_W-1:0] sum_below(int unsigned upto);
    logic [fpst_pkg::DATA_W-1:0] acc;
    acc = '0;
    if (upto > fpst_pkg::SIZE) upto = fpst_pkg::SIZE;
    while (upto > 0) begin
      acc  += node_sum[upto - 1];
      upto &= upto - 1;
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    logic signed [fpst_pkg::DATA_W-1:0] want;
    if (!rst_n) begin
      foreach (node_sum[i]) node_sum[i] = '0;
      owed_sums.delete();
    end else begin
      // results first, so an item accepted this edge cannot mask a stray one
      if (out_valid && out_ready) begin
        if (owed_sums.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %0d",
                   $time, out_prefix_sum);
          errs++;
        end else begin
          want = owed_sums.pop_front();
          if (out_prefix_sum !== want) begin
            $display("%0t: prefix_sum mismatch, expected %0d, got %0d",
                     $time, want, out_prefix_sum);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_req_type)
          fpst_pkg::REQ_UPDATE: add_at(32'(in_position), in_delta);
          fpst_pkg::REQ_QUERY:
            owed_sums.insert(owed_sums.size(), sum_below(32'(in_position)));
          fpst_pkg::REQ_CLEAR:  foreach (node_sum[i]) node_sum[i] = '0;
          default: ;
        endcase
      end
    end
    err_count <= errs;
    sums_owed <= owed_sums.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  // the spare request code, which the block takes and ignores
  localparam logic [fpst_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  // a clear sweeps every entry, so this covers the slowest tail
  localparam int DRAIN_CYCLES = 1100;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic [fpst_pkg::REQ_W-1:0]         in_req_type;
  logic [fpst_pkg::POS_W-1:0]         in_position;
  logic signed [fpst_pkg::DATA_W-1:0] in_delta;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [fpst_pkg::DATA_W-1:0] out_prefix_sum;
  int                                 err_count;
  int                                 sums_owed;

  fenwick_prefix_sum_tree DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_delta       (in_delta),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prefix_sum (out_prefix_sum)
  );

  // watches both channels, predicts every query and compares
  fpst_sum_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // positions: mostly inside the tree, some past the end to exercise the upper bits
  function automatic logic [fpst_pkg::POS_W-1:0] rand_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return fpst_pkg::POS_W'($urandom_range(0, 7));
    if (r < 20) return fpst_pkg::POS_W'($urandom_range(1016, 1024));
    if (r < 90) return fpst_pkg::POS_W'($urandom_range(0, 1024));
    return fpst_pkg::POS_W'($urandom_range(1025, 2047));
  endfunction

  // deltas: full-width noise, small signed values and the extremes
  function automatic logic signed [fpst_pkg::DATA_W-1:0] rand_delta();
    int s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {$urandom, $urandom};
      5, 6, 7: begin
        s = int'($urandom_range(0, 200)) - 100;
        return fpst_pkg::DATA_W'(s);
      end
      8: return $urandom_range(0, 1) ? {1'b0, {(fpst_pkg::DATA_W-1){1'b1}}} :
                                       {1'b1, {(fpst_pkg::DATA_W-1){1'b0}}};
      default: return $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
    endcase
  endfunction

  // present one item from the falling edge and hold it until taken
  task automatic offer(input logic [fpst_pkg::REQ_W-1:0] req,
                       input logic [fpst_pkg::POS_W-1:0] pos,
                       input logic signed [fpst_pkg::DATA_W-1:0] delta);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_delta    <= delta;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid for a gap of length n; zero keeps valid high into the next item
  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // result side: random stalls, ready-only stretches, and one long hold-off
  // once the block is out of its reset sweep, so that queries back up
  initial begin
    int seg;
    int k;
    out_ready = 1'b0;
    @(posedge rst_n);
    while (!in_ready) @(negedge clk);
    for (k = 0; k < 2000; k++) begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 9) < 7);
    end
    // long hold-off while the sender keeps offering
    for (k = 0; k < 400; k++) begin
      @(negedge clk);
      out_ready <= 1'b0;
    end
    forever begin
      seg = $urandom_range(0, 9);
      if (seg < 3) begin
        // always ready
        repeat (100) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
      end else if (seg == 9) begin
        // one longer stall
        repeat ($urandom_range(15, 40)) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        repeat (100) begin
          @(negedge clk);
          out_ready <= ($urandom_range(0, 9) < 7);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int  n;
    int  r;
    int  waited;
    bit  quiet;
    logic [fpst_pkg::REQ_W-1:0] req;

    in_valid    = 1'b0;
    in_req_type = fpst_pkg::REQ_UPDATE;
    in_position = '0;
    in_delta    = '0;
    rst_n       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty tree: empty prefix, whole tree, and a query past the end
    offer(fpst_pkg::REQ_QUERY, 11'd0, 64'sd0);
    offer(fpst_pkg::REQ_QUERY, 11'd1024, 64'sd0);
    offer(fpst_pkg::REQ_QUERY, 11'd2047, rand_delta());
    // extremes of position and delta
    offer(fpst_pkg::REQ_UPDATE, 11'd0, {1'b0, {(fpst_pkg::DATA_W-1){1'b1}}});
    pause(2);
    offer(fpst_pkg::REQ_UPDATE, 11'd1023, {1'b1, {(fpst_pkg::DATA_W-1){1'b0}}});
    offer(fpst_pkg::REQ_UPDATE, 11'd511, -64'sd1);
    // updates outside the tree must change nothing
    offer(fpst_pkg::REQ_UPDATE, 11'd1024, 64'sd12345);
    offer(fpst_pkg::REQ_UPDATE, 11'd2047, -64'sd1);
    offer(fpst_pkg::REQ_QUERY, 11'd1, 64'sd0);
    offer(fpst_pkg::REQ_QUERY, 11'd512, 64'sd0);
    offer(fpst_pkg::REQ_QUERY, 11'd1023, 64'sd0);
    offer(fpst_pkg::REQ_QUERY, 11'd1024, 64'sd0);
    offer(fpst_pkg::REQ_QUERY, 11'd1025, 64'sd0);
    // spare code is taken and ignored
    offer(REQ_SPARE, 11'd3, 64'sd77);
    offer(REQ_SPARE, 11'h7FF, -64'sd1);
    // wrap-around: two maximal deltas on one element
    offer(fpst_pkg::REQ_UPDATE, 11'd3, {1'b0, {(fpst_pkg::DATA_W-1){1'b1}}});
    offer(fpst_pkg::REQ_UPDATE, 11'd3, {1'b0, {(fpst_pkg::DATA_W-1){1'b1}}});
    offer(fpst_pkg::REQ_QUERY, 11'd4, 64'sd0);
    offer(fpst_pkg::REQ_QUERY, 11'd0, 64'sd0);
    // clear, then check the tree is empty and usable again
    offer(fpst_pkg::REQ_CLEAR, 11'd5, 64'sd9);
    offer(fpst_pkg::REQ_QUERY, 11'd1024, 64'sd0);
    offer(fpst_pkg::REQ_UPDATE, 11'd7, 64'sd42);
    offer(fpst_pkg::REQ_QUERY, 11'd8, 64'sd0);
    offer(fpst_pkg::REQ_QUERY, 11'd7, 64'sd0);
    pause(gap_len());

    // random mix, mostly updates and queries, with stretches of back-to-back items
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n / 150) % 4) == 2;
      r = $urandom_range(0, 99);
      if (r < 52)      req = fpst_pkg::REQ_UPDATE;
      else if (r < 94) req = fpst_pkg::REQ_QUERY;
      else if (r < 98) req = REQ_SPARE;
      else             req = fpst_pkg::REQ_CLEAR;
      offer(req, rand_pos(), rand_delta());
      if (!quiet) pause(gap_len());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain outstanding sums, then let a trailing clear finish
    waited = 0;
    while (sums_owed != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sums_owed != 0)
      $display("%0t: %0d query results never arrived", $time, sums_owed);
    if (err_count == 0 && sums_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
